FILE: rtl/mecanum_wheel_speed_mixer_macros.svh
// assertion macros used by the checker of the wheel speed mixer
`ifndef MECANUM_WHEEL_SPEED_MIXER_MACROS_SVH
`define MECANUM_WHEEL_SPEED_MIXER_MACROS_SVH

// property checked on every edge outside reset
`define MWSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked on every edge, reset included
`define MWSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/mwsm_pkg.sv
`timescale 1ns / 1ps
package mwsm_pkg;

  localparam int unsigned NUM_WHEELS = 4;
  localparam int unsigned QUOT_W     = 15;
  localparam int unsigned MAG_W      = 18;
  localparam int unsigned NUM_W      = MAG_W + QUOT_W;
  localparam int unsigned RATE_W     = 16;

  // wheel lanes
  localparam int unsigned WHEEL_FL = 0;
  localparam int unsigned WHEEL_FR = 1;
  localparam int unsigned WHEEL_RL = 2;
  localparam int unsigned WHEEL_RR = 3;

  // register indexes on the configuration port
  localparam logic [1:0] REG_GAIN_X      = 2'd0;
  localparam logic [1:0] REG_GAIN_Y      = 2'd1;
  localparam logic [1:0] REG_GAIN_W      = 2'd2;
  localparam logic [1:0] REG_SPEED_LIMIT = 2'd3;

  typedef struct packed {
    logic [15:0] gain_x;
    logic [15:0] gain_y;
    logic [15:0] gain_w;
    logic [14:0] speed_limit;
  } cfg_t;

  // item handed from the mixing front end to the divider pipeline
  typedef struct packed {
    logic [NUM_WHEELS-1:0][NUM_W-1:0]  num;
    logic [MAG_W-1:0]                  peak;
    logic [NUM_WHEELS-1:0]             neg;
    logic [NUM_WHEELS-1:0][RATE_W-1:0] wheel;
    logic                              scaled;
  } mix_t;

  // one stage of the restoring divider
  typedef struct packed {
    logic [NUM_WHEELS-1:0][MAG_W-1:0]  rem;
    logic [NUM_WHEELS-1:0][QUOT_W-1:0] low;
    logic [NUM_WHEELS-1:0][QUOT_W-1:0] quot;
    logic [MAG_W-1:0]                  peak;
    logic [NUM_WHEELS-1:0]             neg;
    logic [NUM_WHEELS-1:0][RATE_W-1:0] wheel;
    logic                              scaled;
  } div_t;

endpackage

FILE: rtl/mwsm_front.sv
`timescale 1ns / 1ps
module mwsm_front
  import mwsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vel_forward,
  input  logic signed [15:0] vel_sideways,
  input  logic signed [15:0] turn_rate,
  output logic               mix_valid,
  input  logic               mix_ready,
  output mix_t               mix
);

  localparam int unsigned STAGES = 5;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   en;

  // stage 0: products
  logic signed [32:0] prod_x, prod_y, prod_w;
  // stage 1: wheel sums
  logic [NUM_WHEELS-1:0][18:0] sum;
  // stage 2: magnitudes
  logic [NUM_WHEELS-1:0][MAG_W-1:0]  mag2;
  logic [NUM_WHEELS-1:0]             neg2;
  logic [NUM_WHEELS-1:0][RATE_W-1:0] wheel2;
  // stage 3: peak and limit test
  logic [NUM_WHEELS-1:0][MAG_W-1:0]  mag3;
  logic [NUM_WHEELS-1:0]             neg3;
  logic [NUM_WHEELS-1:0][RATE_W-1:0] wheel3;
  logic [MAG_W-1:0]                  peak3;
  logic                              scaled3;

  logic [18:0]      ext_x, ext_y, ext_w;
  logic [MAG_W-1:0] max01, max23, peak_c;

  // stall chain, a bubble is always filled
  always_comb begin
    en[STAGES] = mix_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign mix_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // gain times command
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_x <= $signed({1'b0, cfg.gain_x}) * vel_forward;
      prod_y <= $signed({1'b0, cfg.gain_y}) * vel_sideways;
      prod_w <= $signed({1'b0, cfg.gain_w}) * turn_rate;
    end
  end

  // terms are the products floored by 2^15, then mixed per wheel
  assign ext_x = {prod_x[32], prod_x[32:15]};
  assign ext_y = {prod_y[32], prod_y[32:15]};
  assign ext_w = {prod_w[32], prod_w[32:15]};

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum[WHEEL_FL] <= ext_x - ext_y - ext_w;
      sum[WHEEL_FR] <= ext_x + ext_y + ext_w;
      sum[WHEEL_RL] <= ext_x + ext_y - ext_w;
      sum[WHEEL_RR] <= ext_x - ext_y + ext_w;
    end
  end

  // sign and magnitude per wheel
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
        logic [18:0] m;
        m         = sum[k][18] ? (19'd0 - sum[k]) : sum[k];
        mag2[k]   <= m[MAG_W-1:0];
        neg2[k]   <= sum[k][18];
        wheel2[k] <= sum[k][RATE_W-1:0];
      end
    end
  end

  // largest magnitude
  assign max01  = (mag2[0] > mag2[1]) ? mag2[0] : mag2[1];
  assign max23  = (mag2[2] > mag2[3]) ? mag2[2] : mag2[3];
  assign peak_c = (max01 > max23) ? max01 : max23;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      mag3    <= mag2;
      neg3    <= neg2;
      wheel3  <= wheel2;
      peak3   <= peak_c;
      scaled3 <= peak_c > {3'b000, cfg.speed_limit};
    end
  end

  // dividend of the scaling, magnitude times limit
  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
        mix.num[k] <= {15'd0, mag3[k]} * {18'd0, cfg.speed_limit};
      end
      mix.peak   <= peak3;
      mix.neg    <= neg3;
      mix.wheel  <= wheel3;
      mix.scaled <= scaled3;
    end
  end

endmodule

FILE: rtl/mwsm_div.sv
`timescale 1ns / 1ps
module mwsm_div
  import mwsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               mix_valid,
  output logic               mix_ready,
  input  mix_t               mix,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] front_left_rate,
  output logic signed [15:0] front_right_rate,
  output logic signed [15:0] rear_left_rate,
  output logic signed [15:0] rear_right_rate,
  output logic               was_scaled
);

  localparam int unsigned DIV_STAGES = QUOT_W;
  localparam int unsigned STAGES     = DIV_STAGES + 1;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   en;

  div_t init;
  div_t src [DIV_STAGES];
  div_t nxt [DIV_STAGES];
  div_t st  [DIV_STAGES];

  logic [NUM_WHEELS-1:0][RATE_W-1:0] rate;

  // stall chain
  always_comb begin
    en[STAGES] = out_ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign mix_ready = en[0];
  assign out_valid = vld[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= mix_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // partial remainder starts with the top dividend bits, below the divisor
  always_comb begin
    for (int k = 0; k < NUM_WHEELS; k++) begin
      init.rem[k]  = mix.num[k][NUM_W-1:QUOT_W];
      init.low[k]  = mix.num[k][QUOT_W-1:0];
      init.quot[k] = '0;
    end
    init.peak   = mix.peak;
    init.neg    = mix.neg;
    init.wheel  = mix.wheel;
    init.scaled = mix.scaled;
  end

  // one quotient bit per stage on every lane
  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_step
    if (j == 0) begin : g_first
      assign src[j] = init;
    end else begin : g_next
      assign src[j] = st[j-1];
    end

    always_comb begin
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      logic           fits;
      nxt[j] = src[j];
      for (int k = 0; k < NUM_WHEELS; k++) begin
        trial = {src[j].rem[k], src[j].low[k][QUOT_W-1]};
        diff  = trial - {1'b0, src[j].peak};
        fits  = trial >= {1'b0, src[j].peak};
        nxt[j].rem[k]  = fits ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
        nxt[j].low[k]  = {src[j].low[k][QUOT_W-2:0], 1'b0};
        nxt[j].quot[k] = {src[j].quot[k][QUOT_W-2:0], fits};
      end
    end

    always_ff @(posedge clk) begin
      if (en[j]) begin
        st[j] <= nxt[j];
      end
    end
  end

  // output register: scaled rate with sign restored, or the plain sum
  always_ff @(posedge clk) begin
    if (en[STAGES-1]) begin
      for (int k = 0; k < NUM_WHEELS; k++) begin
        if (!st[DIV_STAGES-1].scaled) begin
          rate[k] <= st[DIV_STAGES-1].wheel[k];
        end else if (st[DIV_STAGES-1].neg[k]) begin
          rate[k] <= 16'd0 - {1'b0, st[DIV_STAGES-1].quot[k]};
        end else begin
          rate[k] <= {1'b0, st[DIV_STAGES-1].quot[k]};
        end
      end
      was_scaled <= st[DIV_STAGES-1].scaled;
    end
  end

  assign front_left_rate  = rate[WHEEL_FL];
  assign front_right_rate = rate[WHEEL_FR];
  assign rear_left_rate   = rate[WHEEL_RL];
  assign rear_right_rate  = rate[WHEEL_RR];

endmodule

FILE: rtl/mecanum_wheel_speed_mixer.sv
`timescale 1ns / 1ps
// channel   | signals                                        | direction
// ----------+------------------------------------------------+----------
// command   | in_valid, in_ready, vel_forward, vel_sideways, | in
//           | turn_rate                                      |
// rates     | out_valid, out_ready, *_rate, was_scaled       | out
// config    | psel, penable, pwrite, paddr, pwdata, prdata,  | in/out
//           | pready                                         |
//
// one command per cycle unless the output stalls; the pipeline has 5 mixing
// stages, 15 restoring divider stages (one quotient bit each), 1 output
// register. each stage holds on its own when the next is blocked, so bubbles
// close up and a stall loses or repeats nothing. synchronous reset empties
// the pipeline and loads the gains and the limit with 1000.
module mecanum_wheel_speed_mixer
  import mwsm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vel_forward,
  input  logic signed [15:0] vel_sideways,
  input  logic signed [15:0] turn_rate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] front_left_rate,
  output logic signed [15:0] front_right_rate,
  output logic signed [15:0] rear_left_rate,
  output logic signed [15:0] rear_right_rate,
  output logic               was_scaled
);

  cfg_t cfg;
  logic mix_valid;
  logic mix_ready;
  mix_t mix;

  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_x      <= 16'd1000;
      cfg.gain_y      <= 16'd1000;
      cfg.gain_w      <= 16'd1000;
      cfg.speed_limit <= 15'd1000;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_GAIN_X:      cfg.gain_x      <= pwdata[15:0];
        REG_GAIN_Y:      cfg.gain_y      <= pwdata[15:0];
        REG_GAIN_W:      cfg.gain_w      <= pwdata[15:0];
        REG_SPEED_LIMIT: cfg.speed_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_GAIN_X:      prdata = {16'd0, cfg.gain_x};
      REG_GAIN_Y:      prdata = {16'd0, cfg.gain_y};
      REG_GAIN_W:      prdata = {16'd0, cfg.gain_w};
      REG_SPEED_LIMIT: prdata = {17'd0, cfg.speed_limit};
      default:         prdata = '0;
    endcase
  end

  mwsm_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .vel_forward  (vel_forward),
    .vel_sideways (vel_sideways),
    .turn_rate    (turn_rate),
    .mix_valid    (mix_valid),
    .mix_ready    (mix_ready),
    .mix          (mix)
  );

  mwsm_div u_div (
    .clk              (clk),
    .rst              (rst),
    .mix_valid        (mix_valid),
    .mix_ready        (mix_ready),
    .mix              (mix),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .front_left_rate  (front_left_rate),
    .front_right_rate (front_right_rate),
    .rear_left_rate   (rear_left_rate),
    .rear_right_rate  (rear_right_rate),
    .was_scaled       (was_scaled)
  );

endmodule

FILE: rtl/mwsm_checker.sv
`timescale 1ns / 1ps
`include "mecanum_wheel_speed_mixer_macros.svh"
module mwsm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] front_left_rate,
  input logic [15:0] front_right_rate,
  input logic [15:0] rear_left_rate,
  input logic [15:0] rear_right_rate,
  input logic        was_scaled
);

  logic        rate_at_min;
  logic        out_stall;
  logic [64:0] result_bits;

  // any wheel rate at the most negative code
  assign rate_at_min = (front_left_rate == 16'h8000) || (front_right_rate == 16'h8000) ||
                       (rear_left_rate == 16'h8000) || (rear_right_rate == 16'h8000);

  // result offered but not taken
  assign out_stall   = out_valid && !out_ready;
  assign result_bits = {front_left_rate, front_right_rate, rear_left_rate, rear_right_rate,
                        was_scaled};

  // pipeline empties on reset
  `MWSM_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result valid right after reset")

  // input backs up only when every stage is full and the output is stalled
  `MWSM_ASSERT(a_backpressure, !in_ready |-> out_stall, "input blocked without output stall")

  // a scaled rate never reaches the most negative code
  `MWSM_ASSERT(a_scaled_range, (out_valid && was_scaled) |-> !rate_at_min, "scaled rate out of range")

  // stalled result holds
  `MWSM_ASSERT(a_out_hold, out_stall |=> (out_valid && $stable(result_bits)), "stalled result changed")

endmodule

bind mecanum_wheel_speed_mixer mwsm_checker u_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import mwsm_pkg::*;

  localparam logic signed [15:0] CMD_MAX     = 16'sh7FFF;
  localparam logic signed [15:0] CMD_MIN     = 16'sh8000;
  localparam int                 HOLD_CYCLES = 120;
  localparam int                 QUIET_LIMIT = 2000;
  localparam int                 DRAIN_TAIL  = 30;

  typedef struct {
    logic [RATE_W-1:0] rate [NUM_WHEELS];
    logic              scaled;
  } wheel_rates_t;

  // expected wheel rates for every accepted command, oldest first
  class wheel_rate_checker;
    logic [15:0]  gain_x;
    logic [15:0]  gain_y;
    logic [15:0]  gain_w;
    logic [14:0]  speed_limit;
    wheel_rates_t expected_rates [$];
    int           mismatches;
    string        wheel_name [NUM_WHEELS];

    function new();
      gain_x      = 16'd1000;
      gain_y      = 16'd1000;
      gain_w      = 16'd1000;
      speed_limit = 15'd1000;
      mismatches  = 0;
      wheel_name  = '{"front_left", "front_right", "rear_left", "rear_right"};
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
      case (index)
        REG_GAIN_X:      gain_x = value[15:0];
        REG_GAIN_Y:      gain_y = value[15:0];
        REG_GAIN_W:      gain_w = value[15:0];
        REG_SPEED_LIMIT: speed_limit = value[14:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_rates.size();
    endfunction

    // inverse kinematics followed by proportional scaling to the limit
    function wheel_rates_t mix_wheels(logic signed [15:0] fwd, logic signed [15:0] side,
                                      logic signed [15:0] turn);
      wheel_rates_t r;
      longint       tx, ty, tw, peak, lim, q;
      longint       sum [NUM_WHEELS];
      tx = (longint'(gain_x) * longint'(fwd)) >>> 15;
      ty = (longint'(gain_y) * longint'(side)) >>> 15;
      tw = (longint'(gain_w) * longint'(turn)) >>> 15;
      sum[WHEEL_FL] = tx - ty - tw;
      sum[WHEEL_FR] = tx + ty + tw;
      sum[WHEEL_RL] = tx + ty - tw;
      sum[WHEEL_RR] = tx - ty + tw;
      lim  = longint'(speed_limit);
      peak = 0;
      for (int k = 0; k < NUM_WHEELS; k++) begin
        if ((sum[k] < 0 ? -sum[k] : sum[k]) > peak) peak = sum[k] < 0 ? -sum[k] : sum[k];
      end
      r.scaled = (peak > lim);
      for (int k = 0; k < NUM_WHEELS; k++) begin
        if (r.scaled) begin
          q = (sum[k] < 0 ? -sum[k] : sum[k]) * lim / peak;
          sum[k] = sum[k] < 0 ? -q : q;
        end
        r.rate[k] = 16'(sum[k]);
      end
      return r;
    endfunction

    function void note_command(logic signed [15:0] fwd, logic signed [15:0] side,
                               logic signed [15:0] turn);
      expected_rates.push_back(mix_wheels(fwd, side, turn));
    endfunction

    task report(string msg);
      if (mismatches < 50) $display("mismatch at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_rates(wheel_rates_t got);
      wheel_rates_t want;
      if (expected_rates.size() == 0) begin
        report("wheel rates arrived with no command outstanding");
      end else begin
        want = expected_rates.pop_front();
        for (int k = 0; k < NUM_WHEELS; k++) begin
          if (got.rate[k] !== want.rate[k])
            report($sformatf("%s rate: expected %0d, got %0d", wheel_name[k],
                             $signed(want.rate[k]), $signed(got.rate[k])));
        end
        if (got.scaled !== want.scaled)
          report($sformatf("was_scaled: expected %0b, got %0b", want.scaled, got.scaled));
      end
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [15:0] vel_forward = '0;
  logic signed [15:0] vel_sideways = '0;
  logic signed [15:0] turn_rate = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] front_left_rate;
  logic signed [15:0] front_right_rate;
  logic signed [15:0] rear_left_rate;
  logic signed [15:0] rear_right_rate;
  logic               was_scaled;

  wheel_rate_checker chk = new();
  bit                idle_enable = 1'b1;
  bit                hold_off_req = 1'b0;
  int                quiet_cycles = 0;

  mecanum_wheel_speed_mixer uut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .vel_forward      (vel_forward),
    .vel_sideways     (vel_sideways),
    .turn_rate        (turn_rate),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .front_left_rate  (front_left_rate),
    .front_right_rate (front_right_rate),
    .rear_left_rate   (rear_left_rate),
    .rear_right_rate  (rear_right_rate),
    .was_scaled       (was_scaled)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // result transactions go to the checker
  always @(posedge clk) begin
    wheel_rates_t got;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      got.rate[WHEEL_FL] = front_left_rate;
      got.rate[WHEEL_FR] = front_right_rate;
      got.rate[WHEEL_RL] = rear_left_rate;
      got.rate[WHEEL_RR] = rear_right_rate;
      got.scaled         = was_scaled;
      chk.check_rates(got);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready) ||
        (psel && penable && pwrite && pready === 1'b1))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else if (idle_enable && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // one command transaction; called at a rising edge
  task automatic send_command(input logic signed [15:0] fwd, input logic signed [15:0] side,
                              input logic signed [15:0] turn);
    in_valid     <= 1'b1;
    vel_forward  <= fwd;
    vel_sideways <= side;
    turn_rate    <= turn;
    do @(posedge clk); while (in_ready !== 1'b1);
    chk.note_command(fwd, side, turn);
  endtask

  task automatic sender_gap();
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  // wait until every expected result has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  // setup and access phase of one register write
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {index, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    chk.set_register(index, value);
    @(posedge clk);
  endtask

  // unused upper data bits carry junk, the block must drop them
  task automatic apply_config(input logic [15:0] gx, input logic [15:0] gy,
                              input logic [15:0] gw, input logic [14:0] lim);
    write_register(REG_GAIN_X, {16'($urandom), gx});
    write_register(REG_GAIN_Y, {16'($urandom), gy});
    write_register(REG_GAIN_W, {16'($urandom), gw});
    write_register(REG_SPEED_LIMIT, {17'($urandom), lim});
  endtask

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 2000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [14:0] pick_limit();
    case ($urandom_range(0, 5))
      0:       return 15'd1;
      1:       return 15'h7FFF;
      2:       return 15'($urandom_range(1, 2000));
      default: return 15'($urandom_range(1, 32767));
    endcase
  endfunction

  function automatic logic signed [15:0] random_command();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 4))
          0:       return CMD_MIN;
          1:       return CMD_MAX;
          2:       return -16'sd1;
          3:       return 16'sd1;
          default: return 16'sd0;
        endcase
      end
      1, 2:    return 16'($urandom_range(0, 4095)) - 16'sd2048;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic run_commands(input int count);
    for (int i = 0; i < count; i++) begin
      send_command(random_command(), random_command(), random_command());
      sender_gap();
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: extremes, rounding of small negatives, unscaled cases
    send_command(16'sd0, 16'sd0, 16'sd0);
    send_command(CMD_MAX, 16'sd0, 16'sd0);
    send_command(CMD_MIN, 16'sd0, 16'sd0);
    send_command(16'sd0, CMD_MAX, 16'sd0);
    send_command(16'sd0, CMD_MIN, 16'sd0);
    send_command(16'sd0, 16'sd0, CMD_MAX);
    send_command(16'sd0, 16'sd0, CMD_MIN);
    send_command(CMD_MAX, CMD_MAX, CMD_MAX);
    send_command(CMD_MIN, CMD_MIN, CMD_MIN);
    send_command(CMD_MAX, CMD_MIN, CMD_MAX);
    send_command(-16'sd1, -16'sd1, -16'sd1);
    send_command(16'sd1, 16'sd1, 16'sd1);
    send_command(16'sd5000, -16'sd3000, 16'sd2000);
    send_command(16'sd10000, 16'sd10000, 16'sd0);
    run_commands(150);
    drain();

    // largest gains and limit
    apply_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    send_command(CMD_MIN, CMD_MIN, CMD_MIN);
    send_command(CMD_MAX, CMD_MIN, CMD_MIN);
    run_commands(150);
    drain();

    // zero gains, smallest limit
    apply_config(16'd0, 16'd0, 16'd0, 15'd1);
    run_commands(50);
    drain();

    // limit of zero: any motion collapses to zero
    apply_config(pick_gain(), pick_gain(), pick_gain(), 15'd0);
    send_command(16'sd0, 16'sd0, 16'sd0);
    send_command(CMD_MAX, 16'sd0, 16'sd0);
    run_commands(100);
    drain();

    // random settings, with a long output hold-off and a sender pause
    for (int p = 0; p < 8; p++) begin
      apply_config(pick_gain(), pick_gain(), pick_gain(), pick_limit());
      if (p == 2) begin
        hold_off_req = 1'b1;
        repeat (80) send_command(random_command(), random_command(), random_command());
      end else if (p == 4) begin
        run_commands(60);
        drain();
        run_commands(60);
      end else begin
        run_commands(120);
      end
      drain();
    end

    // last part at full rate, no idling on either side
    idle_enable = 1'b0;
    apply_config(pick_gain(), pick_gain(), pick_gain(), pick_limit());
    run_commands(360);
    drain();
    repeat (DRAIN_TAIL) @(posedge clk);

    if (chk.mismatches == 0 && chk.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
